@@ rtl/core/nss_pkg.sv @@
package nss_pkg;

	localparam int COORD_W = 24;
	localparam int DIST_W = 52;
	localparam int MUL_W = 26;
	localparam int PROD_W = 2 * MUL_W;
	localparam int MAX_PARTS_DEF = 256;
	localparam int MAX_VERTICES_DEF = 65536;
	localparam int FRAC_BITS_DEF = 16;
	localparam logic [DIST_W-1:0] DIST_ALL_ONES = '1;

	typedef enum logic [0:0] {
		REG_QUERY_X = 1'b0,
		REG_QUERY_Y = 1'b1
	} reg_index_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] vertex_x;
		logic signed [COORD_W-1:0] vertex_y;
		logic part_start;
		logic last_vertex;
	} item_t;

	typedef struct packed {
		logic [7:0] best_part;
		logic [15:0] best_vertex;
		logic found;
		logic [DIST_W-1:0] min_distance_sq;
	} result_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_ACCEPT,
		OP_MDXX,
		OP_MDYY,
		OP_MUX,
		OP_MUY,
		OP_NUMADD,
		OP_CLAMP_A,
		OP_CLAMP_B,
		OP_DIVINIT,
		OP_DIVSTEP,
		OP_MDXT,
		OP_MDYT,
		OP_PY,
		OP_EXY,
		OP_MEX,
		OP_MEY,
		OP_DADD,
		OP_UPDATE,
		OP_FINISH
	} op_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_MDXX,
		S_MDYY,
		S_MUX,
		S_MUY,
		S_NUMADD,
		S_DECIDE,
		S_DIV,
		S_MDXT,
		S_MDYT,
		S_PY,
		S_EXY,
		S_MEX,
		S_MEY,
		S_DADD,
		S_UPDATE,
		S_FINISH
	} state_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic seg_now;
		logic den_zero;
		logic num_le0;
		logic num_ge_den;
	} status_t;

endpackage

@@ rtl/core/nss_datapath.sv @@
module nss_datapath
	import nss_pkg::*;
#(
	parameter int MAX_PARTS = MAX_PARTS_DEF,
	parameter int MAX_VERTICES = MAX_VERTICES_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  reg_index_t cfg_index,
	input  logic [COORD_W-1:0] cfg_data,
	input  item_t item,
	input  cmd_t cmd,
	output status_t status,
	output logic done,
	output result_t result
);

	localparam int PW = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
	localparam int VW = $clog2(MAX_VERTICES);
	localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) <<< (FRAC_BITS - 1);

	logic signed [COORD_W-1:0] qx_q, qy_q, prev_x_q, prev_y_q;
	logic have_prev_q, lv_q, found_q, done_q;
	logic [PW-1:0] part_q, best_part_q;
	logic [VW-1:0] vcnt_q, best_vertex_q;
	logic [DIST_W-1:0] best_q, dist_q;
	logic signed [COORD_W-1:0] ax_q, ay_q, bx_q, by_q;
	logic signed [MUL_W-1:0] dx_q, dy_q, ux_q, uy_q, px_q, py_q, ex_q, ey_q;
	logic signed [PROD_W-1:0] prod_s1, den_q, num_q;
	logic [PROD_W-1:0] r_q, r2;
	logic [FRAC_BITS-1:0] t_q;
	logic signed [MUL_W-1:0] ma, mb;
	logic signed [PROD_W-1:0] rnd;
	result_t result_q;

	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.op)
			OP_MDXX: begin ma = dx_q; mb = dx_q; end
			OP_MDYY: begin ma = dy_q; mb = dy_q; end
			OP_MUX: begin ma = ux_q; mb = dx_q; end
			OP_MUY: begin ma = uy_q; mb = dy_q; end
			OP_MDXT: begin ma = dx_q; mb = $signed(MUL_W'(t_q)); end
			OP_MDYT: begin ma = dy_q; mb = $signed(MUL_W'(t_q)); end
			OP_MEX: begin ma = ex_q; mb = ex_q; end
			OP_MEY: begin ma = ey_q; mb = ey_q; end
			default: ;
		endcase
	end

	assign rnd = (prod_s1 + HALF) >>> FRAC_BITS;
	assign r2 = {r_q[PROD_W-2:0], 1'b0};

	assign status.seg_now = have_prev_q && !item.part_start;
	assign status.den_zero = (den_q == '0);
	assign status.num_le0 = (num_q <= 0);
	assign status.num_ge_den = (num_q >= den_q);

	always_ff @(posedge clk) begin
		prod_s1 <= ma * mb;
		case (cmd.op)
			OP_ACCEPT: begin
				ax_q <= prev_x_q;
				ay_q <= prev_y_q;
				bx_q <= item.vertex_x;
				by_q <= item.vertex_y;
				dx_q <= MUL_W'(item.vertex_x) - MUL_W'(prev_x_q);
				dy_q <= MUL_W'(item.vertex_y) - MUL_W'(prev_y_q);
				ux_q <= MUL_W'(qx_q) - MUL_W'(prev_x_q);
				uy_q <= MUL_W'(qy_q) - MUL_W'(prev_y_q);
			end
			OP_MDYY: den_q <= prod_s1;
			OP_MUX: den_q <= den_q + prod_s1;
			OP_MUY: num_q <= prod_s1;
			OP_NUMADD: num_q <= num_q + prod_s1;
			OP_CLAMP_A: begin px_q <= MUL_W'(ax_q); py_q <= MUL_W'(ay_q); end
			OP_CLAMP_B: begin px_q <= MUL_W'(bx_q); py_q <= MUL_W'(by_q); end
			OP_DIVINIT: begin r_q <= num_q; t_q <= '0; end
			OP_DIVSTEP: begin
				if (r2 >= den_q) begin
					r_q <= r2 - den_q;
					t_q <= {t_q[FRAC_BITS-2:0], 1'b1};
				end else begin
					r_q <= r2;
					t_q <= {t_q[FRAC_BITS-2:0], 1'b0};
				end
			end
			OP_MDYT: px_q <= MUL_W'(ax_q) + MUL_W'(rnd);
			OP_PY: py_q <= MUL_W'(ay_q) + MUL_W'(rnd);
			OP_EXY: begin
				ex_q <= px_q - MUL_W'(qx_q);
				ey_q <= py_q - MUL_W'(qy_q);
			end
			OP_MEY: dist_q <= DIST_W'(prod_s1);
			OP_DADD: dist_q <= dist_q + DIST_W'(prod_s1);
			OP_FINISH: begin
				if (found_q) begin
					result_q.best_part <= 8'(best_part_q);
					result_q.best_vertex <= 16'(best_vertex_q);
					result_q.found <= 1'b1;
					result_q.min_distance_sq <= best_q;
				end else begin
					result_q.best_part <= '0;
					result_q.best_vertex <= '0;
					result_q.found <= 1'b0;
					result_q.min_distance_sq <= DIST_ALL_ONES;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qx_q <= '0;
			qy_q <= '0;
			prev_x_q <= '0;
			prev_y_q <= '0;
			have_prev_q <= 1'b0;
			lv_q <= 1'b0;
			part_q <= '0;
			vcnt_q <= '0;
			best_q <= DIST_ALL_ONES;
			best_part_q <= '0;
			best_vertex_q <= '0;
			found_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cmd.op == OP_FINISH) && lv_q;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_QUERY_X: qx_q <= cfg_data;
					REG_QUERY_Y: qy_q <= cfg_data;
					default: ;
				endcase
			end
			case (cmd.op)
				OP_ACCEPT: begin
					lv_q <= item.last_vertex;
					prev_x_q <= item.vertex_x;
					prev_y_q <= item.vertex_y;
					have_prev_q <= 1'b1;
					if (!have_prev_q) begin
						vcnt_q <= '0;
					end else if (item.part_start) begin
						if (part_q < PW'(MAX_PARTS - 1))
							part_q <= part_q + 1'b1;
						vcnt_q <= '0;
					end else if (vcnt_q < VW'(MAX_VERTICES - 1)) begin
						vcnt_q <= vcnt_q + 1'b1;
					end
				end
				OP_UPDATE: begin
					if (dist_q < best_q) begin
						best_q <= dist_q;
						best_part_q <= part_q;
						best_vertex_q <= vcnt_q;
						found_q <= 1'b1;
					end
				end
				OP_FINISH: begin
					if (lv_q) begin
						prev_x_q <= '0;
						prev_y_q <= '0;
						have_prev_q <= 1'b0;
						part_q <= '0;
						vcnt_q <= '0;
						best_q <= DIST_ALL_ONES;
						best_part_q <= '0;
						best_vertex_q <= '0;
						found_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	assign done = done_q;
	assign result = result_q;

endmodule

@@ rtl/core/nss_control.sv @@
module nss_control
	import nss_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  status_t status,
	output logic busy,
	output cmd_t cmd
);

	localparam int CW = $clog2(FRAC_BITS);

	state_t state_q, state_d;
	logic [CW-1:0] cnt_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (start) state_d = status.seg_now ? S_MDXX : S_FINISH;
			S_MDXX: state_d = S_MDYY;
			S_MDYY: state_d = S_MUX;
			S_MUX: state_d = S_MUY;
			S_MUY: state_d = S_NUMADD;
			S_NUMADD: state_d = S_DECIDE;
			S_DECIDE: begin
				if (status.den_zero) state_d = S_FINISH;
				else if (status.num_le0 || status.num_ge_den) state_d = S_EXY;
				else state_d = S_DIV;
			end
			S_DIV: if (cnt_q == CW'(FRAC_BITS - 1)) state_d = S_MDXT;
			S_MDXT: state_d = S_MDYT;
			S_MDYT: state_d = S_PY;
			S_PY: state_d = S_EXY;
			S_EXY: state_d = S_MEX;
			S_MEX: state_d = S_MEY;
			S_MEY: state_d = S_DADD;
			S_DADD: state_d = S_UPDATE;
			S_UPDATE: state_d = S_FINISH;
			S_FINISH: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd.op = OP_NONE;
		unique case (state_q)
			S_IDLE: if (start) cmd.op = OP_ACCEPT;
			S_MDXX: cmd.op = OP_MDXX;
			S_MDYY: cmd.op = OP_MDYY;
			S_MUX: cmd.op = OP_MUX;
			S_MUY: cmd.op = OP_MUY;
			S_NUMADD: cmd.op = OP_NUMADD;
			S_DECIDE: begin
				if (status.den_zero) cmd.op = OP_NONE;
				else if (status.num_le0) cmd.op = OP_CLAMP_A;
				else if (status.num_ge_den) cmd.op = OP_CLAMP_B;
				else cmd.op = OP_DIVINIT;
			end
			S_DIV: cmd.op = OP_DIVSTEP;
			S_MDXT: cmd.op = OP_MDXT;
			S_MDYT: cmd.op = OP_MDYT;
			S_PY: cmd.op = OP_PY;
			S_EXY: cmd.op = OP_EXY;
			S_MEX: cmd.op = OP_MEX;
			S_MEY: cmd.op = OP_MEY;
			S_DADD: cmd.op = OP_DADD;
			S_UPDATE: cmd.op = OP_UPDATE;
			S_FINISH: cmd.op = OP_FINISH;
			default: cmd.op = OP_NONE;
		endcase
	end

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DIV) cnt_q <= cnt_q + 1'b1;
			else cnt_q <= '0;
		end
	end

endmodule

@@ rtl/core/nearest_segment_insertion_search.sv @@
// Nearest segment search: load query_x/query_y, then feed polyline vertices one
// per start pulse while busy is low. A vertex that closes no segment goes
// straight to finish; a zero-length segment finishes once its length is
// known; a clamped projection skips the bit-serial divider that an interior
// projection uses; all products go through the single shared 26x26 multiplier. On
// the vertex marked last_vertex the result shows on result for one cycle with done
// high, and must be taken then: there is no way to hold it off.
module nearest_segment_insertion_search
	import nss_pkg::*;
#(
	parameter int MAX_PARTS = MAX_PARTS_DEF,
	parameter int MAX_VERTICES = MAX_VERTICES_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  reg_index_t cfg_index,
	input  logic [COORD_W-1:0] cfg_data,
	input  logic start,
	input  item_t item,
	output logic busy,
	output logic done,
	output result_t result
);

	cmd_t cmd;
	status_t status;

	nss_control #(.FRAC_BITS(FRAC_BITS)) u_control (
		.clk(clk), .arst_n(arst_n), .start(start), .status(status),
		.busy(busy), .cmd(cmd)
	);

	nss_datapath #(
		.MAX_PARTS(MAX_PARTS), .MAX_VERTICES(MAX_VERTICES), .FRAC_BITS(FRAC_BITS)
	) u_datapath (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .item(item), .cmd(cmd), .status(status),
		.done(done), .result(result)
	);

endmodule

@@ rtl/core/nss_checker.sv @@
module nss_checker
	import nss_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  logic done,
	input  result_t result
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without work in progress");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.found |-> result.min_distance_sq == DIST_ALL_ONES
			&& result.best_part == '0 && result.best_vertex == '0)
		else $error("empty result not cleared");

endmodule

bind nearest_segment_insertion_search nss_checker u_nss_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.result(result)
);
